/* src/utf16_to_utf8_encoder_assert.svh */
// Assertion helpers shared by the transcoder modules.
`ifndef UTF16_TO_UTF8_ENCODER_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U16U8_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("transcoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define U16U8_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("transcoder check failed");

`endif

/* src/u16u8_pkg.sv */
package u16u8_pkg;

  // Most bytes that one code unit can cause: a flushed surrogate plus a
  // three-byte unit.
  localparam int JobBytes = 6;
  localparam int CountW = 3;

  typedef logic [JobBytes-1:0][7:0] job_bytes_t;

  // One classified item: bytes[0] goes out first.
  typedef struct packed {
    logic [CountW-1:0] count;
    job_bytes_t        bytes;
  } job_t;

endpackage

/* src/utf16_to_utf8_encoder.sv */
// UTF-16 to UTF-8 transcoder. Push one UTF-16 code unit at a time, with
// end_of_text set on the last unit of a text; the UTF-8 bytes come out of the
// result queue one per cycle while pop is held, and last_of_run marks the
// final byte that each unit caused. A high surrogate causes no bytes until the
// next unit shows whether it pairs with a low surrogate; a surrogate that
// cannot pair goes out as its own three-byte sequence. The input side takes a
// unit in any cycle in which the two-entry job queue has room, so units can
// enter while the bytes of earlier units still drain; a unit's job passes
// through the queue to the byte serializer. A unit causes 0 to 6 bytes: none
// for a held high surrogate, 1 to 3 for a unit on its own, 4 for a surrogate
// pair, and 3 more when a held surrogate is flushed ahead of the unit.
// Nothing is held across reset.
module utf16_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);
  import u16u8_pkg::*;

  logic job_ready;
  logic accept;
  logic job_push;
  job_t front_job;
  logic fifo_full;
  logic fifo_valid;
  job_t fifo_job;
  logic job_take;

  assign job_ready = !fifo_full;
  assign full      = fifo_full;

  u16u8_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .code_unit   (code_unit),
    .end_of_text (end_of_text),
    .job_ready   (job_ready),
    .accept      (accept),
    .job_push    (job_push),
    .job         (front_job)
  );

  u16u8_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push && accept),
    .wr_job   (front_job),
    .full     (fifo_full),
    .rd_en    (job_take),
    .rd_valid (fifo_valid),
    .rd_job   (fifo_job)
  );

  u16u8_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (fifo_valid),
    .job         (fifo_job),
    .job_take    (job_take),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

/* src/u16u8_front.sv */
`include "utf16_to_utf8_encoder_assert.svh"

module u16u8_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [15:0]     code_unit,
  input  logic            end_of_text,
  input  logic            job_ready,
  output logic            accept,
  output logic            job_push,
  output u16u8_pkg::job_t job
);
  import u16u8_pkg::*;

  localparam logic [5:0]  HighTag  = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  LowTag   = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [20:0] PlaneOne = 21'h10000;

  logic       held;
  logic [9:0] held_bits;
  logic       held_next;
  logic [9:0] held_bits_next;

  logic                unit_high;
  logic                unit_low;
  logic [2:0][7:0]     unit_bytes;
  logic [1:0]          unit_count;
  logic                unit_hold;
  logic [15:0]         held_unit;
  logic [20:0]         code_point;

  assign unit_high = (code_unit[15:10] == HighTag);
  assign unit_low  = (code_unit[15:10] == LowTag);
  assign held_unit = {HighTag, held_bits};
  assign code_point = {1'b0, held_bits, code_unit[9:0]} + PlaneOne;

  assign accept = push && job_ready;

  // Bytes for the incoming unit on its own, as if nothing were held.
  always_comb begin
    unit_bytes = '0;
    unit_count = 2'd0;
    unit_hold  = 1'b0;
    priority if (code_unit[15:7] == 9'd0) begin
      unit_bytes[0] = code_unit[7:0];
      unit_count    = 2'd1;
    end else if (code_unit[15:11] == 5'd0) begin
      unit_bytes[0] = {3'b110, code_unit[10:6]};
      unit_bytes[1] = {2'b10, code_unit[5:0]};
      unit_count    = 2'd2;
    end else if (unit_high && !end_of_text) begin
      unit_hold = 1'b1;
    end else begin
      unit_bytes[0] = {4'hE, code_unit[15:12]};
      unit_bytes[1] = {2'b10, code_unit[11:6]};
      unit_bytes[2] = {2'b10, code_unit[5:0]};
      unit_count    = 2'd3;
    end
  end

  always_comb begin
    job            = '0;
    held_next      = unit_hold;
    held_bits_next = code_unit[9:0];
    priority if (held && unit_low) begin
      held_next    = 1'b0;
      job.bytes[0] = {5'b11110, code_point[20:18]};
      job.bytes[1] = {2'b10, code_point[17:12]};
      job.bytes[2] = {2'b10, code_point[11:6]};
      job.bytes[3] = {2'b10, code_point[5:0]};
      job.count    = CountW'(4);
    end else if (held) begin
      // The held surrogate goes out alone, then the new unit follows.
      job.bytes[0] = {4'hE, held_unit[15:12]};
      job.bytes[1] = {2'b10, held_unit[11:6]};
      job.bytes[2] = {2'b10, held_unit[5:0]};
      job.bytes[3] = unit_bytes[0];
      job.bytes[4] = unit_bytes[1];
      job.bytes[5] = unit_bytes[2];
      job.count    = CountW'(3) + CountW'(unit_count);
    end else begin
      job.bytes[0] = unit_bytes[0];
      job.bytes[1] = unit_bytes[1];
      job.bytes[2] = unit_bytes[2];
      job.count    = CountW'(unit_count);
    end
  end

  assign job_push = accept && (job.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bits <= held_bits_next;
    end
  end

  `U16U8_ASSERT_NEXT(a_pair_releases, clk, rst, accept && held && unit_low, !held)

endmodule

/* src/u16u8_fifo.sv */
`include "utf16_to_utf8_encoder_assert.svh"

module u16u8_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  u16u8_pkg::job_t wr_job,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output u16u8_pkg::job_t rd_job
);
  import u16u8_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count[1];
  assign rd_valid = (count != 2'd0);
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  `U16U8_ASSERT_NOW(a_no_overflow, clk, rst, wr_en, !full || rd_en)
  `U16U8_ASSERT_NOW(a_no_underflow, clk, rst, rd_en, rd_valid)

endmodule

/* src/u16u8_back.sv */
`include "utf16_to_utf8_encoder_assert.svh"

module u16u8_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  u16u8_pkg::job_t job,
  output logic            job_take,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);
  import u16u8_pkg::*;

  job_bytes_t        bytes;
  logic [CountW-1:0] remaining;
  logic              transfer;
  logic              load;

  assign empty       = (remaining == '0);
  assign transfer    = pop && !empty;
  assign out_byte    = bytes[0];
  assign last_of_run = (remaining == CountW'(1));

  // A new job may enter in the same cycle as the last byte of the current one leaves.
  assign load     = empty || (transfer && last_of_run);
  assign job_take = load && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= job_valid ? job.count : '0;
    end else if (transfer) begin
      remaining <= remaining - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      bytes <= job.bytes;
    end else if (transfer) begin
      bytes <= {8'h00, bytes[JobBytes-1:1]};
    end
  end

  `U16U8_ASSERT_NEXT(a_hold_byte, clk, rst, !empty && !pop, $stable(out_byte) && !empty)
  `U16U8_ASSERT_NOW(a_take_when_free, clk, rst, job_take, empty || transfer)

endmodule
